// ----- design/cwsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsd_pkg
// Shared types, register codes and constants for the contracted Woods-Saxon
// density evaluator.
// ----------------------------------------------------------------------------
package cwsd_pkg;

  typedef enum logic [2:0] {
    REG_RADIUS  = 3'd0,
    REG_IMPACT  = 3'd1,
    REG_DIFFUSE = 3'd2,
    REG_DENSITY = 3'd3,
    REG_GAMMA   = 3'd4
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [15:0] RADIUS_RST  = 16'd6533;
  localparam logic [15:0] IMPACT_RST  = 16'd0;
  localparam logic [15:0] DIFFUSE_RST = 16'd2191;
  localparam logic [15:0] DENSITY_RST = 16'd11141;
  localparam logic [31:0] GAMMA_RST   = 32'd65536;

  // Number of exponent bits, one table factor each.
  localparam int EXP_BITS = 22;

  // Divider for the exp argument: 22 quotient bits over a 16-bit divisor.
  localparam int ARG_QW = 22;
  localparam int ARG_DW = 16;
  localparam int ARG_LAT = ARG_QW / 2;

  // round(2^30 * exp(-2^(i-16))).
  localparam logic [29:0] EXP_TAB [EXP_BITS] = '{
    30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
    30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
    30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
    30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
    30'd395007542,  30'd145315154,  30'd19666268,   30'd360200,
    30'd121,        30'd0
  };

endpackage

// ----- design/cwsd_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsd_isqrt
// Pipelined integer square root, two result bits per register stage.
// ----------------------------------------------------------------------------
module cwsd_isqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [2*RW-1:0] in_rad,
  output logic            out_vld,
  output logic [RW-1:0]   out_root
);

  localparam int NS  = RW / 2;
  localparam int RMW = RW + 3;

  logic            vld  [NS+1];
  logic [2*RW-1:0] rad  [NS+1];
  logic [RMW-1:0]  rem  [NS+1];
  logic [RW-1:0]   root [NS+1];

  assign vld[0]  = in_vld;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RMW-1:0]  t1, t2, tr1, tr2, r1, r2;
    logic [RW-1:0]   q1, q2;
    logic            b1, b2;

    always_comb begin
      t1  = {rem[k][RMW-3:0], rad[k][2*RW-1:2*RW-2]};
      tr1 = {1'b0, root[k], 2'b01};
      b1  = t1 >= tr1;
      r1  = b1 ? t1 - tr1 : t1;
      q1  = {root[k][RW-2:0], b1};
      t2  = {r1[RMW-3:0], rad[k][2*RW-3:2*RW-4]};
      tr2 = {1'b0, q1, 2'b01};
      b2  = t2 >= tr2;
      r2  = b2 ? t2 - tr2 : t2;
      q2  = {q1[RW-2:0], b2};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
      if (adv) begin
        rad[k+1]  <= {rad[k][2*RW-5:0], 4'b0};
        rem[k+1]  <= r2;
        root[k+1] <= q2;
      end
    end
  end

  assign out_vld  = vld[NS];
  assign out_root = root[NS];

endmodule

// ----- design/cwsd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsd_div
// Pipelined restoring divider, two quotient bits per register stage. The
// starting partial remainder must already be below the divisor.
// ----------------------------------------------------------------------------
module cwsd_div #(
  parameter int DW = 16,
  parameter int QW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  output logic          out_vld,
  output logic [QW-1:0] out_quo
);

  localparam int NS = QW / 2;

  logic          vld [NS+1];
  logic [DW-1:0] rem [NS+1];
  logic [QW-1:0] num [NS+1];
  logic [DW-1:0] den [NS+1];
  logic [QW-1:0] quo [NS+1];

  assign vld[0] = in_vld;
  assign rem[0] = in_rem;
  assign num[0] = in_num;
  assign den[0] = in_den;
  assign quo[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW:0] t1, t2, r1, r2, dd;
    logic        b1, b2;

    always_comb begin
      dd = {1'b0, den[k]};
      t1 = {rem[k], num[k][QW-1]};
      b1 = t1 >= dd;
      r1 = b1 ? t1 - dd : t1;
      t2 = {r1[DW-1:0], num[k][QW-2]};
      b2 = t2 >= dd;
      r2 = b2 ? t2 - dd : t2;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
      if (adv) begin
        rem[k+1] <= r2[DW-1:0];
        num[k+1] <= {num[k][QW-3:0], 2'b0};
        den[k+1] <= den[k];
        quo[k+1] <= {quo[k][QW-3:0], b1, b2};
      end
    end
  end

  assign out_vld = vld[NS];
  assign out_quo = quo[NS];

endmodule

// ----- design/contracted_woods_saxon_density.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contracted_woods_saxon_density
// Lorentz-contracted Woods-Saxon number density gamma*n0/(1+exp((r-R)/d)).
//
//   channel | direction | handshake         | payload
//   in      | sink      | in_valid/in_stall | x_coord, y_coord, z_coord, nucleus_side
//   out     | source    | out_valid/out_stall | density
//   cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One point enters per cycle while the output is not stalled; the pipeline
// is made of the square root (16 stages), two dividers (11 and 16 stages),
// the exp chain (22 multiply stages) and eight single register stages. Reset
// clears all valid bits and loads register defaults. A stalled output beat
// freezes the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module contracted_woods_saxon_density (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 x_coord,
  input  logic signed [15:0]                 y_coord,
  input  logic signed [15:0]                 z_coord,
  input  logic                               nucleus_side,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        density,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cwsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cwsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import cwsd_pkg::*;

  logic [15:0] radius, impact, diffuse, n0;
  logic [31:0] gamma;
  logic [15:0] dval;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign dval      = (diffuse == 16'd0) ? 16'd1 : diffuse;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= RADIUS_RST;
      impact  <= IMPACT_RST;
      diffuse <= DIFFUSE_RST;
      n0      <= DENSITY_RST;
      gamma   <= GAMMA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS:  radius  <= cfg_data[15:0];
        REG_IMPACT:  impact  <= cfg_data[15:0];
        REG_DIFFUSE: diffuse <= cfg_data[15:0];
        REG_DENSITY: n0      <= cfg_data[15:0];
        REG_GAMMA:   gamma   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: offsets from the nucleus centre, in units of 2^-11 fm.
  logic signed [17:0] dxs, dys;
  logic [15:0]        zm;
  logic [16:0]        dxm_a, dym_a;
  logic [47:0]        gzp_a;
  logic               va;

  always_comb begin
    dxs = nucleus_side ? {x_coord[15], x_coord, 1'b0} - {{2{impact[15]}}, impact}
                       : {x_coord[15], x_coord, 1'b0} + {{2{impact[15]}}, impact};
    dys = {y_coord[15], y_coord, 1'b0};
    zm  = z_coord[15] ? 16'(-z_coord) : 16'(z_coord);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
    if (adv) begin
      dxm_a <= dxs[17] ? 17'(-dxs) : dxs[16:0];
      dym_a <= dys[17] ? 17'(-dys) : dys[16:0];
      gzp_a <= gamma * zm;
    end
  end

  // Stage B: squares.
  logic [30:0] gz;
  logic [33:0] dx2_b, dy2_b;
  logic [61:0] gz2_b;
  logic        vb;

  assign gz = (gzp_a[47:46] != 2'b00) ? 31'h7FFF_FFFF : gzp_a[45:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
    if (adv) begin
      dx2_b <= dxm_a * dxm_a;
      dy2_b <= dym_a * dym_a;
      gz2_b <= gz * gz;
    end
  end

  // Stage C: sum of squares.
  logic [63:0] rad_c;
  logic        vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= vb;
    end
    if (adv) begin
      rad_c <= {30'd0, dx2_b} + {30'd0, dy2_b} + {2'd0, gz2_b};
    end
  end

  logic        vr;
  logic [31:0] root;

  cwsd_isqrt #(.RW(32)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (vc),
    .in_rad   (rad_c),
    .out_vld  (vr),
    .out_root (root)
  );

  // Stage D: r - 2R, its magnitude and the saturation test |u| of at least 64.
  logic signed [33:0] diff;
  logic [32:0]        dmag;
  logic               vd, neg_d, sat_d;
  logic [32:0]        mag_d;

  always_comb begin
    diff = $signed({2'b00, root}) - $signed({17'd0, radius, 1'b0});
    dmag = diff[33] ? 33'(-diff) : diff[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= vr;
    end
    if (adv) begin
      neg_d <= diff[33];
      mag_d <= dmag;
      sat_d <= dmag >= {12'd0, dval, 5'd0};
    end
  end

  // A saturated argument divides all ones by one, which the clamp then caps.
  logic [ARG_DW-1:0] arg_rem, arg_den;
  logic [ARG_QW-1:0] arg_num, arg_q;
  logic              varg;
  logic              neg_line [ARG_LAT+1];

  assign arg_rem = sat_d ? '0 : mag_d[20:5];
  assign arg_num = sat_d ? '1 : {mag_d[4:0], 17'd0};
  assign arg_den = sat_d ? 16'd1 : dval;

  cwsd_div #(.DW(ARG_DW), .QW(ARG_QW)) u_arg_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (vd),
    .in_rem  (arg_rem),
    .in_num  (arg_num),
    .in_den  (arg_den),
    .out_vld (varg),
    .out_quo (arg_q)
  );

  assign neg_line[0] = neg_d;
  for (genvar k = 0; k < ARG_LAT; k++) begin : g_neg
    always_ff @(posedge clk) begin
      if (adv) begin
        neg_line[k+1] <= neg_line[k];
      end
    end
  end

  // Stage E: clamp and sign of u.
  localparam logic [ARG_QW-1:0] ULIM = ARG_QW'(1) << (ARG_QW - 1);

  logic [ARG_QW-1:0] a_cl;
  assign a_cl = (arg_q > ULIM) ? ULIM : arg_q;

  logic              ev   [EXP_BITS+1];
  logic [30:0]       ee   [EXP_BITS+1];
  logic [ARG_QW-1:0] ea   [EXP_BITS+1];
  logic              epos [EXP_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ev[0] <= 1'b0;
    end else if (adv) begin
      ev[0] <= varg;
    end
    if (adv) begin
      ee[0]   <= 31'h4000_0000;
      ea[0]   <= a_cl;
      epos[0] <= !(neg_line[ARG_LAT] && (a_cl != '0));
    end
  end

  // exp(-a): one table factor per stage for each set bit of a.
  for (genvar k = 0; k < EXP_BITS; k++) begin : g_exp
    logic [60:0] prod;
    assign prod = ee[k] * EXP_TAB[k] + 61'h2000_0000;

    always_ff @(posedge clk) begin
      if (rst) begin
        ev[k+1] <= 1'b0;
      end else if (adv) begin
        ev[k+1] <= ev[k];
      end
      if (adv) begin
        ee[k+1]   <= ea[k][k] ? prod[60:30] : ee[k];
        ea[k+1]   <= ea[k];
        epos[k+1] <= epos[k];
      end
    end
  end

  // Logistic factor f in Q1.30.
  logic [30:0] ef;
  logic [31:0] f_rem, f_num, f_den, f_q;
  logic        vf;

  assign ef    = ee[EXP_BITS];
  assign f_rem = epos[EXP_BITS] ? {3'd0, ef[30:2]} : 32'h1000_0000;
  assign f_num = epos[EXP_BITS] ? {ef[1:0], 30'd0} : 32'd0;
  assign f_den = 32'h4000_0000 + {1'b0, ef};

  cwsd_div #(.DW(32), .QW(32)) u_f_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (ev[EXP_BITS]),
    .in_rem  (f_rem),
    .in_num  (f_num),
    .in_den  (f_den),
    .out_vld (vf),
    .out_quo (f_q)
  );

  // Stage G: gamma*n0.
  logic [47:0] p_g;
  logic [30:0] f_g;
  logic        vg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= vf;
    end
    if (adv) begin
      p_g <= gamma * n0;
      f_g <= f_q[30:0];
    end
  end

  // Stage H: partial products of p*f.
  logic [63:0] m1_h;
  logic [62:0] m2_h;
  logic        vh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (adv) begin
      vh <= vg;
    end
    if (adv) begin
      m1_h <= p_g * f_g[30:15];
      m2_h <= p_g * f_g[14:0];
    end
  end

  // Stage I: scale and saturate into the output register.
  logic [64:0] acc;
  assign acc = {1'b0, m1_h} + {17'd0, m2_h[62:15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vh;
    end
    if (adv) begin
      density <= (acc[64:63] != 2'b00) ? 32'hFFFF_FFFF : acc[62:31];
    end
  end

endmodule

// ----- sim/cwsd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsd_checker
// Watches the point, density and register channels of the contracted
// Woods-Saxon density evaluator, predicts each density from its own copy of
// the registers and compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module cwsd_checker import cwsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [15:0]      x_coord,
  input  logic signed [15:0]      y_coord,
  input  logic signed [15:0]      z_coord,
  input  logic                    nucleus_side,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [31:0]             density,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output int                      pending,
  output int                      errors
);

  logic [15:0]        radius_q;
  logic signed [15:0] impact_q;
  logic [15:0]        diffuse_q;
  logic [15:0]        n0_q;
  logic [31:0]        gamma_q;

  logic [31:0] density_q [$];

  function automatic logic [31:0] predict_density(input logic signed [15:0] x,
                                                  input logic signed [15:0] y,
                                                  input logic signed [15:0] z,
                                                  input logic right);
    longint dx, dy, az, diff, u;
    longint unsigned dxm, dym, gz, rem, root, bitv, d, a, e, f, p, fh, fl, acc;
    dx = right ? 2 * longint'(x) - longint'(impact_q) : 2 * longint'(x) + longint'(impact_q);
    dy = 2 * longint'(y);
    az = (z < 0) ? -longint'(z) : longint'(z);
    dxm = (dx < 0) ? -dx : dx;
    dym = (dy < 0) ? -dy : dy;
    gz = (longint'(gamma_q) * az) >> 15;
    if (gz > 64'h7FFF_FFFF) gz = 64'h7FFF_FFFF;
    // Bitwise integer square root of the squared distance.
    rem = dxm * dxm + dym * dym + gz * gz;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    d = (diffuse_q == 0) ? 1 : diffuse_q;
    diff = longint'(root) - 2 * longint'(radius_q);
    u = (diff * 131072) / longint'(d);
    if (u > 2097152) u = 2097152;
    if (u < -2097152) u = -2097152;
    a = (u < 0) ? -u : u;
    e = 64'd1 << 30;
    for (int i = 0; i < EXP_BITS; i++)
      if (a[i]) e = (e * EXP_TAB[i] + (64'd1 << 29)) >> 30;
    if (u >= 0) f = (e << 30) / ((64'd1 << 30) + e);
    else        f = (64'd1 << 60) / ((64'd1 << 30) + e);
    p = longint'(gamma_q) * n0_q;
    fh = f >> 15;
    fl = f & 64'h7FFF;
    acc = (p * fh + ((p * fl) >> 15)) >> 31;
    return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
  endfunction

  assign pending = density_q.size();

  always @(posedge clk) begin
    if (rst) begin
      radius_q  <= RADIUS_RST;
      impact_q  <= IMPACT_RST;
      diffuse_q <= DIFFUSE_RST;
      n0_q      <= DENSITY_RST;
      gamma_q   <= GAMMA_RST;
      density_q.delete();
      errors    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS:  radius_q  <= cfg_data[15:0];
          REG_IMPACT:  impact_q  <= cfg_data[15:0];
          REG_DIFFUSE: diffuse_q <= cfg_data[15:0];
          REG_DENSITY: n0_q      <= cfg_data[15:0];
          REG_GAMMA:   gamma_q   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        density_q.push_back(predict_density(x_coord, y_coord, z_coord, nucleus_side));
      if (out_valid && !out_stall) begin
        if (density_q.size() == 0) begin
          $display("%0t: density beat %h with no prediction waiting", $time, density);
          errors <= errors + 1;
        end else if (density !== density_q[0]) begin
          $display("%0t: density mismatch, expected %h, actual %h",
                   $time, density_q[0], density);
          errors <= errors + 1;
          void'(density_q.pop_front());
        end else begin
          void'(density_q.pop_front());
        end
      end
    end
  end

endmodule

// ----- sim/contracted_woods_saxon_density_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contracted_woods_saxon_density_tb
// Drives directed and random sample points through the density evaluator
// under several register settings, with random gaps and output stalls, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module contracted_woods_saxon_density_tb;
  import cwsd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] x_coord = '0;
  logic signed [15:0] y_coord = '0;
  logic signed [15:0] z_coord = '0;
  logic nucleus_side = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] density;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int pending;
  int errors;
  bit gaps_on = 1'b1;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  contracted_woods_saxon_density dut (.*);

  cwsd_checker u_checker (.*);

  always @(negedge clk)
    out_stall <= gaps_on && ($urandom_range(99) < 20);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic side);
    while (gaps_on && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    x_coord = x;
    y_coord = y;
    z_coord = z;
    nucleus_side = side;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every predicted density has come back out.
  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_regs(input logic [15:0] r, input logic [15:0] b,
                           input logic [15:0] d, input logic [15:0] n0,
                           input logic [31:0] g);
    drain();
    write_reg(REG_RADIUS, {16'd0, r});
    write_reg(REG_IMPACT, {16'd0, b});
    write_reg(REG_DIFFUSE, {16'd0, d});
    write_reg(REG_DENSITY, {16'd0, n0});
    write_reg(REG_GAMMA, g);
  endtask

  // Half the points sit within about 16 fm of the nuclei, where the density
  // varies; the rest span the full coordinate range.
  task automatic random_points(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1))
        send_point(16'($urandom_range(32767) - 16384), 16'($urandom_range(32767) - 16384),
                   16'($urandom_range(32767) - 16384), 1'($urandom_range(1)));
      else
        send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed points under the reset settings.
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd6533, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd6533, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd6533, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7FFF, 16'sd0, 1'b1);
    send_point(16'sd1024, -16'sd1024, 16'sd512, 1'b0);
    send_point(16'sd7000, 16'sd100, -16'sd200, 1'b1);

    // Register extremes: zero diffuseness, widest impact, largest gamma.
    load_regs(16'd0, 16'h8000, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sh8000, 16'sd0, 16'sd1, 1'b0);
    send_point(16'sh7FFF, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sh7FFF, 1'b0);
    // Zero gamma gives zero density; gamma below one is taken as written.
    load_regs(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'd0, 32'd0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd100, 16'sd0, 16'sd0, 1'b0);
    load_regs(16'd6533, 16'd4096, 16'd1, 16'hFFFF, 32'd32768);
    send_point(16'sd2048, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd6533, 16'sd0, 16'sd0, 1'b0);
    // An out-of-range register index must change nothing.
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_point(16'sd0, 16'sd1000, 16'sd0, 1'b0);

    load_regs(RADIUS_RST, IMPACT_RST, DIFFUSE_RST, DENSITY_RST, GAMMA_RST);
    random_points(150);
    // One stretch with no gaps or stalls.
    gaps_on = 1'b0;
    random_points(150);
    gaps_on = 1'b1;
    drain();
    random_points(50);

    for (int ph = 0; ph < 6; ph++) begin
      load_regs(16'($urandom_range(12000)), 16'($urandom), 16'($urandom_range(65535, 1)),
                16'($urandom), (ph == 5) ? $urandom : 32'd65536 + $urandom_range(2000000));
      random_points(140);
    end

    drain();
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
design/cwsd_pkg.sv
design/cwsd_isqrt.sv
design/cwsd_div.sv
design/contracted_woods_saxon_density.sv
sim/cwsd_checker.sv
sim/contracted_woods_saxon_density_tb.sv
